/* rtl/srs1_pkg.sv */
// Shared types, codes and the microcode table of the S-record stream encoder.
package srs1_pkg;

  localparam int RECORD_BYTES = 16;
  localparam int BUF_DEPTH = 16;
  localparam int IDX_W = 4;
  localparam int FILL_W = 5;
  localparam int STEP_W = 6;

  localparam logic [FILL_W-1:0] RECORD_FILL = FILL_W'(RECORD_BYTES);

  // input commands
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END = 1'b1;

  // register index (paddr[2])
  localparam logic REG_BASE_ADDRESS = 1'b0;

  // jump kinds; each also implies the datapath action of its step
  localparam logic [1:0] J_NEXT = 2'd0;   // step + 1
  localparam logic [1:0] J_LOOP = 2'd1;   // next data byte or fall through
  localparam logic [1:0] J_S1END = 2'd2;  // commit record, S5 if end pending
  localparam logic [1:0] J_STOP = 2'd3;   // clear stream, stop

  // character source
  localparam logic [1:0] SRC_CONST = 2'd0;
  localparam logic [1:0] SRC_HI = 2'd1;
  localparam logic [1:0] SRC_LO = 2'd2;

  // byte select for hex digits
  localparam logic [2:0] BS_CNT1 = 3'd0;
  localparam logic [2:0] BS_RA_HI = 3'd1;
  localparam logic [2:0] BS_RA_LO = 3'd2;
  localparam logic [2:0] BS_DATA = 3'd3;
  localparam logic [2:0] BS_CK1 = 3'd4;
  localparam logic [2:0] BS_RC_HI = 3'd5;
  localparam logic [2:0] BS_RC_LO = 3'd6;
  localparam logic [2:0] BS_CK5 = 3'd7;

  // entry points of the program
  localparam logic [STEP_W-1:0] ST_S1 = 6'd0;
  localparam logic [STEP_W-1:0] ST_DATA = 6'd8;
  localparam logic [STEP_W-1:0] ST_S5 = 6'd13;

  localparam logic [6:0] CH_S = 7'h53;
  localparam logic [6:0] CH_0 = 7'h30;
  localparam logic [6:0] CH_1 = 7'h31;
  localparam logic [6:0] CH_3 = 7'h33;
  localparam logic [6:0] CH_5 = 7'h35;
  localparam logic [6:0] CH_9 = 7'h39;
  localparam logic [6:0] CH_C = 7'h43;
  localparam logic [6:0] CH_F = 7'h46;
  localparam logic [6:0] CH_NL = 7'h0A;

  typedef struct packed {
    logic [1:0] jmp;
    logic [1:0] src;
    logic [2:0] bsel;
    logic [6:0] ch;
  } uword_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic last;
    logic inc;
    logic commit;
    logic clear;
    logic [1:0] src;
    logic [2:0] bsel;
    logic [6:0] ch;
  } seq_ctl_t;

  function automatic uword_t uw_c(input logic [6:0] ch, input logic [1:0] jmp);
    uword_t w;
    w.jmp = jmp;
    w.src = SRC_CONST;
    w.bsel = BS_CNT1;
    w.ch = ch;
    return w;
  endfunction

  function automatic uword_t uw_h(input logic [1:0] src, input logic [2:0] bsel,
                                  input logic [1:0] jmp);
    uword_t w;
    w.jmp = jmp;
    w.src = src;
    w.bsel = bsel;
    w.ch = CH_0;
    return w;
  endfunction

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      // S1 record
      6'd0: w = uw_c(CH_S, J_NEXT);
      6'd1: w = uw_c(CH_1, J_NEXT);
      6'd2: w = uw_h(SRC_HI, BS_CNT1, J_NEXT);
      6'd3: w = uw_h(SRC_LO, BS_CNT1, J_NEXT);
      6'd4: w = uw_h(SRC_HI, BS_RA_HI, J_NEXT);
      6'd5: w = uw_h(SRC_LO, BS_RA_HI, J_NEXT);
      6'd6: w = uw_h(SRC_HI, BS_RA_LO, J_NEXT);
      6'd7: w = uw_h(SRC_LO, BS_RA_LO, J_NEXT);
      6'd8: w = uw_h(SRC_HI, BS_DATA, J_NEXT);
      6'd9: w = uw_h(SRC_LO, BS_DATA, J_LOOP);
      6'd10: w = uw_h(SRC_HI, BS_CK1, J_NEXT);
      6'd11: w = uw_h(SRC_LO, BS_CK1, J_NEXT);
      6'd12: w = uw_c(CH_NL, J_S1END);
      // S5 record
      6'd13: w = uw_c(CH_S, J_NEXT);
      6'd14: w = uw_c(CH_5, J_NEXT);
      6'd15: w = uw_c(CH_0, J_NEXT);
      6'd16: w = uw_c(CH_3, J_NEXT);
      6'd17: w = uw_h(SRC_HI, BS_RC_HI, J_NEXT);
      6'd18: w = uw_h(SRC_LO, BS_RC_HI, J_NEXT);
      6'd19: w = uw_h(SRC_HI, BS_RC_LO, J_NEXT);
      6'd20: w = uw_h(SRC_LO, BS_RC_LO, J_NEXT);
      6'd21: w = uw_h(SRC_HI, BS_CK5, J_NEXT);
      6'd22: w = uw_h(SRC_LO, BS_CK5, J_NEXT);
      6'd23: w = uw_c(CH_NL, J_NEXT);
      // S9 record, fixed text with checksum FC
      6'd24: w = uw_c(CH_S, J_NEXT);
      6'd25: w = uw_c(CH_9, J_NEXT);
      6'd26: w = uw_c(CH_0, J_NEXT);
      6'd27: w = uw_c(CH_3, J_NEXT);
      6'd28: w = uw_c(CH_0, J_NEXT);
      6'd29: w = uw_c(CH_0, J_NEXT);
      6'd30: w = uw_c(CH_0, J_NEXT);
      6'd31: w = uw_c(CH_0, J_NEXT);
      6'd32: w = uw_c(CH_F, J_NEXT);
      6'd33: w = uw_c(CH_C, J_NEXT);
      6'd34: w = uw_c(CH_NL, J_STOP);
      default: w = uw_c(CH_NL, J_STOP);
    endcase
    return w;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (7'h30 + {3'b000, n}) : (7'h37 + {3'b000, n});
  endfunction

endpackage

/* rtl/srs1_seq.sv */
// Microcode sequencer: step counter, control ROM and jump logic.
module srs1_seq import srs1_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [STEP_W-1:0] start_step,
  input  logic              end_cmd,
  input  logic              go,
  input  logic              loop_more,
  output seq_ctl_t          ctl
);

  logic [STEP_W-1:0] step;
  logic              busy;
  logic              end_pending;
  uword_t            uw;
  logic              emit;

  assign uw = ucode(step);
  assign emit = busy & go;

  always_comb begin
    ctl.busy = busy;
    ctl.emit = emit;
    ctl.last = emit & ((uw.jmp == J_STOP) | ((uw.jmp == J_S1END) & ~end_pending));
    ctl.inc = emit & (uw.jmp == J_LOOP);
    ctl.commit = emit & (uw.jmp == J_S1END);
    ctl.clear = emit & (uw.jmp == J_STOP);
    ctl.src = uw.src;
    ctl.bsel = uw.bsel;
    ctl.ch = uw.ch;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= ST_S1;
      end_pending <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= start_step;
      end_pending <= end_cmd;
    end else if (emit) begin
      case (uw.jmp)
        J_NEXT: step <= step + 1'b1;
        J_LOOP: step <= loop_more ? ST_DATA : step + 1'b1;
        J_S1END: begin
          if (end_pending) step <= ST_S5;
          else busy <= 1'b0;
        end
        default: busy <= 1'b0;
      endcase
    end
  end

endmodule

/* rtl/srecord_s1_stream_encoder_unit.sv */
// Top level of the S-record stream encoder: byte buffer, record state, text output.
// Takes raw bytes and end commands and emits S-record text one ASCII character per
// cycle. A data byte that does not complete a record is stored in the buffer and
// emits nothing. The byte that completes a record of n bytes starts an S1 record
// of 11 + 2n characters (43 for 16 bytes); an end command emits a flushed partial
// S1 record if bytes are pending, then 22 characters of S5 and S9. Characters come
// from a microcoded sequencer that issues one character per cycle into the output
// register while the output is not stalled, and in_stall stays high while record
// text is going out. Output stalls hold the sequencer. base_address is written
// over the APB port at byte address 0.
module srecord_s1_stream_encoder_unit import srs1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char,
  output logic        last_char,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]        byte_buffer [BUF_DEPTH];
  logic [FILL_W-1:0] fill_count;
  logic [15:0]       record_address;
  logic [15:0]       record_counter;
  logic [7:0]        data_sum;
  logic [15:0]       base_address;
  logic [IDX_W-1:0]  idx;

  seq_ctl_t          ctl;
  logic              accept;
  logic              cfg_write;
  logic [FILL_W-1:0] fill_inc;
  logic              start;
  logic [STEP_W-1:0] start_step;
  logic              loop_more;
  logic [7:0]        cnt1;
  logic [7:0]        ck1;
  logic [7:0]        ck5;
  logic [7:0]        sel_byte;
  logic [6:0]        char_next;

  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_BASE_ADDRESS) ? {16'h0000, base_address} : 32'h0;

  assign in_stall = ctl.busy;
  assign accept = in_valid & ~in_stall;
  assign fill_inc = fill_count + 1'b1;
  assign start = accept & ((command == CMD_END) | (fill_inc >= RECORD_FILL));
  assign start_step = ((command == CMD_END) && (fill_count == '0)) ? ST_S5 : ST_S1;
  assign loop_more = ({1'b0, idx} + 1'b1) < fill_count;

  srs1_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_step (start_step),
    .end_cmd    (command),
    .go         (~out_valid | ~out_stall),
    .loop_more  (loop_more),
    .ctl        (ctl)
  );

  assign cnt1 = 8'(fill_count) + 8'd3;
  assign ck1 = ~(cnt1 + record_address[15:8] + record_address[7:0] + data_sum);
  assign ck5 = ~(8'd3 + record_counter[15:8] + record_counter[7:0]);

  always_comb begin
    case (ctl.bsel)
      BS_CNT1:  sel_byte = cnt1;
      BS_RA_HI: sel_byte = record_address[15:8];
      BS_RA_LO: sel_byte = record_address[7:0];
      BS_DATA:  sel_byte = byte_buffer[idx];
      BS_CK1:   sel_byte = ck1;
      BS_RC_HI: sel_byte = record_counter[15:8];
      BS_RC_LO: sel_byte = record_counter[7:0];
      default:  sel_byte = ck5;
    endcase
    case (ctl.src)
      SRC_HI:  char_next = hex_char(sel_byte[7:4]);
      SRC_LO:  char_next = hex_char(sel_byte[3:0]);
      default: char_next = ctl.ch;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && command == CMD_DATA) byte_buffer[fill_count[IDX_W-1:0]] <= data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      record_address <= 16'h0000;
      record_counter <= 16'h0000;
      data_sum <= 8'h00;
      base_address <= 16'h0000;
      idx <= '0;
    end else begin
      if (cfg_write && paddr[2] == REG_BASE_ADDRESS) begin
        base_address <= pwdata[15:0];
        if (fill_count == '0 && record_counter == 16'h0000) record_address <= pwdata[15:0];
      end
      if (accept && command == CMD_DATA) begin
        fill_count <= fill_inc;
        data_sum <= data_sum + data_byte;
      end
      if (start) idx <= '0;
      if (ctl.inc) idx <= idx + 1'b1;
      if (ctl.commit) begin
        record_address <= record_address + 16'(RECORD_BYTES);
        record_counter <= record_counter + 1'b1;
        fill_count <= '0;
        data_sum <= 8'h00;
        idx <= '0;
      end
      if (ctl.clear) begin
        record_address <= base_address;
        record_counter <= 16'h0000;
        fill_count <= '0;
        data_sum <= 8'h00;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_char <= char_next;
      last_char <= ctl.last;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_slot_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!out_valid || !out_stall))
    else $error("character issued into an occupied output register");

  a_commit_clears_fill: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |=> (fill_count == '0 && data_sum == 8'h00))
    else $error("record commit left pending bytes");

  a_idle_not_full: assert property (@(posedge clk) disable iff (rst)
    !ctl.busy |-> (fill_count < RECORD_FILL))
    else $error("full buffer while sequencer idle");

  a_last_stops: assert property (@(posedge clk) disable iff (rst)
    ctl.last |=> !ctl.busy)
    else $error("sequencer still running after last character");
`endif

endmodule

/* tb/tb.sv */
// Testbench of the S-record stream encoder: directed and random requests against a predictor.
`timescale 1ns / 100ps

module tb;
  import srs1_pkg::*;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } text_char_t;

  typedef struct packed {
    logic       canned;  // expected text is the fixed empty-stream trailer
    logic       cmd;
    logic [7:0] byt;
  } dir_row_t;

  typedef enum int {
    PACE_FULL,
    PACE_SENDER_IDLE,
    PACE_RECEIVER_STALL,
    PACE_BOTH
  } pace_t;

  localparam int         DIR_ROWS = 22;
  localparam logic [2:0] ADDR_BASE = {REG_BASE_ADDRESS, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        command;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  out_char;
  logic        last_char;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // predictor state
  logic [7:0]  pend_buf [16];
  logic [4:0]  pend_fill;
  logic [7:0]  pend_sum;
  logic [15:0] next_addr;
  logic [15:0] rec_count;
  logic [15:0] base_reg;

  text_char_t  text_q[$];   // characters still owed by the block
  text_char_t  req_text[$]; // characters caused by the current request
  text_char_t  want;
  int          mismatches;
  int          idle_pct;
  int          stall_pct;

  // empty-stream trailer, a full record wrapping the address, a partial flush, another trailer
  dir_row_t dir_tab [DIR_ROWS] = '{
    {1'b1, CMD_END,  8'h00},
    {1'b0, CMD_DATA, 8'h00}, {1'b0, CMD_DATA, 8'hFF}, {1'b0, CMD_DATA, 8'h01},
    {1'b0, CMD_DATA, 8'h02}, {1'b0, CMD_DATA, 8'h04}, {1'b0, CMD_DATA, 8'h08},
    {1'b0, CMD_DATA, 8'h10}, {1'b0, CMD_DATA, 8'h20}, {1'b0, CMD_DATA, 8'h40},
    {1'b0, CMD_DATA, 8'h80}, {1'b0, CMD_DATA, 8'hFE}, {1'b0, CMD_DATA, 8'hFD},
    {1'b0, CMD_DATA, 8'hFB}, {1'b0, CMD_DATA, 8'hF7}, {1'b0, CMD_DATA, 8'hA5},
    {1'b0, CMD_DATA, 8'h5A},
    {1'b0, CMD_DATA, 8'hFF}, {1'b0, CMD_DATA, 8'h00}, {1'b0, CMD_DATA, 8'h9C},
    {1'b0, CMD_END,  8'hFF},
    {1'b1, CMD_END,  8'h3C}
  };

  srecord_s1_stream_encoder_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .last_char (last_char),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  task automatic put_ch(input logic [7:0] c);
    req_text.push_back({c[6:0], 1'b0});
  endtask

  task automatic put_hex8(input logic [7:0] v);
    put_ch(hex_digit(v[7:4]));
    put_ch(hex_digit(v[3:0]));
  endtask

  task automatic put_record(input logic [7:0] kind, input logic [15:0] addr, input int len,
                            input logic [7:0] psum);
    logic [7:0] cnt;
    logic [7:0] ck;
    cnt = 8'(3 + len);
    ck = ~(cnt + addr[15:8] + addr[7:0] + psum);
    put_ch("S");
    put_ch(kind);
    put_hex8(cnt);
    put_hex8(addr[15:8]);
    put_hex8(addr[7:0]);
    for (int i = 0; i < len; i++) put_hex8(pend_buf[i]);
    put_hex8(ck);
    put_ch(8'h0A);
  endtask

  task automatic data_record();
    put_record("1", next_addr, int'(pend_fill), pend_sum);
    next_addr = next_addr + 16'(RECORD_BYTES);
    rec_count = rec_count + 16'd1;
    pend_fill = 5'd0;
    pend_sum = 8'd0;
  endtask

  task automatic predict_text(input logic cmd, input logic [7:0] byt);
    req_text.delete();
    if (cmd == CMD_DATA) begin
      pend_buf[pend_fill[3:0]] = byt;
      pend_fill = pend_fill + 5'd1;
      pend_sum = pend_sum + byt;
      if (pend_fill >= RECORD_FILL) data_record();
    end else begin
      if (pend_fill != 5'd0) data_record();
      put_record("5", rec_count, 0, 8'h00);
      put_record("9", 16'h0000, 0, 8'h00);
      pend_fill = 5'd0;
      pend_sum = 8'd0;
      rec_count = 16'd0;
      next_addr = base_reg;
    end
  endtask

  task automatic send_request(input logic cmd, input logic [7:0] byt, input logic canned);
    string s;
    text_char_t c;
    s = "S5030000FC\nS9030000FC\n";
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    data_byte = byt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_text(cmd, byt);
    if (canned) begin
      req_text.delete();
      for (int i = 0; i < s.len(); i++) put_ch(s[i]);
    end
    for (int i = 0; i < req_text.size(); i++) begin
      c = req_text[i];
      c.last = (i == req_text.size() - 1);
      text_q.push_back(c);
    end
  endtask

  // sender holds off until every owed character is out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (text_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_BASE) begin
      base_reg = val[15:0];
      if (pend_fill == 5'd0 && rec_count == 16'd0) next_addr = base_reg;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_pace(input pace_t p);
    case (p)
      PACE_FULL: begin
        idle_pct = 0;
        stall_pct = 0;
      end
      PACE_SENDER_IDLE: begin
        idle_pct = 57;
        stall_pct = 0;
      end
      PACE_RECEIVER_STALL: begin
        idle_pct = 0;
        stall_pct = 57;
      end
      default: begin
        idle_pct = 9;
        stall_pct = 9;
      end
    endcase
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (text_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected char %h last %b", out_char, last_char);
        end else begin
          want = text_q.pop_front();
          if (out_char !== want.ch || last_char !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("char exp %h got %h, last exp %b got %b",
                       want.ch, out_char, want.last, last_char);
          end
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic        cmd;
    logic [7:0]  byt;
    logic [15:0] base_val;
    rst = 1'b1;
    in_valid = 1'b0;
    command = CMD_DATA;
    data_byte = 8'h00;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    mismatches = 0;
    for (int i = 0; i < 16; i++) pend_buf[i] = 8'h00;
    pend_fill = 5'd0;
    pend_sum = 8'd0;
    next_addr = 16'h0000;
    rec_count = 16'h0000;
    base_reg = 16'h0000;
    set_pace(PACE_FULL);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // first record lands at FFF8, so the next one wraps to 0008
    reg_write(ADDR_BASE, 32'h0000_FFF8);
    for (int i = 0; i < DIR_ROWS; i++)
      send_request(dir_tab[i].cmd, dir_tab[i].byt, dir_tab[i].canned);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_pace(pace_t'(ph % 4));
      case (ph)
        0: base_val = 16'hFFFF;
        1: base_val = 16'h0000;
        default: base_val = 16'($urandom_range(0, 65535));
      endcase
      // may land mid-stream, where the new base waits for the next end
      reg_write(ADDR_BASE, {16'($urandom_range(0, 65535)), base_val});
      if (ph == 2) reg_write(ADDR_UNMAPPED, $urandom());
      for (int k = 0; k < 17; k++) begin
        cmd = ($urandom_range(0, 19) == 0) ? CMD_END : CMD_DATA;
        case ($urandom_range(0, 7))
          0: byt = 8'h00;
          1: byt = 8'hFF;
          default: byt = 8'($urandom_range(0, 255));
        endcase
        send_request(cmd, byt, 1'b0);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (text_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/srs1_pkg.sv
rtl/srs1_seq.sv
rtl/srecord_s1_stream_encoder_unit.sv
tb/tb.sv
